>>> rtl/srrw_pkg.sv
// Shared constants and codes for the selective repeat receive window.
package srrw_pkg;

   localparam int SEQ_BITS  = 3;
   localparam int SEQ_SPACE = 1 << SEQ_BITS;

   typedef logic [SEQ_BITS-1:0] seq_type;

   localparam logic KIND_ACK  = 1'b0;
   localparam logic KIND_DATA = 1'b1;

endpackage

>>> rtl/srrw_if.sv
// Valid/ready channel interfaces for packets in and acknowledgements or payloads out.
interface srrw_req_if
   import srrw_pkg::*;
#(
   parameter int PAYLOAD_BITS = 32
) ();
   logic                    valid;
   logic                    ready;
   seq_type                 seq_num;
   logic                    checksum_ok;
   logic [PAYLOAD_BITS-1:0] payload_word;

   modport source (output valid, output seq_num, output checksum_ok, output payload_word,
                   input ready);
   modport sink   (input valid, input seq_num, input checksum_ok, input payload_word,
                   output ready);
endinterface

interface srrw_rsp_if
   import srrw_pkg::*;
#(
   parameter int PAYLOAD_BITS = 32
) ();
   logic                    valid;
   logic                    ready;
   logic                    result_kind;
   seq_type                 ack_num;
   logic [PAYLOAD_BITS-1:0] delivered_payload;
   logic                    last_of_run;

   modport source (output valid, output result_kind, output ack_num,
                   output delivered_payload, output last_of_run, input ready);
   modport sink   (input valid, input result_kind, input ack_num,
                   input delivered_payload, input last_of_run, output ready);
endinterface

>>> rtl/selective_repeat_receive_window.sv
// Selective repeat receiver: window buffer, acknowledgement and in-order delivery sequencer.
//
// Usage:
//   req_ch carries one data packet per transaction: seq_num, checksum_ok and payload_word.
//   rsp_ch carries one result per transaction: an acknowledgement (result_kind 0, ack_num)
//   or a delivered payload (result_kind 1, delivered_payload); last_of_run marks the final
//   result caused by a packet.
//   A packet with a bad checksum, or outside both the receive and the previous window,
//   gives no result and changes nothing. An in-window packet is stored, acknowledged, and
//   then the run of filled slots from the window base is delivered in order.
//   Timing: req_ch.ready is high only while the sequencer is idle. An accepted packet goes to
//   the acknowledge state, which writes its acknowledgement into the output register; then,
//   unless rsp_ch stalls, one delivery per cycle follows from the head slot, a run of 0 to
//   WINDOW_SIZE payloads. The single head read port of the slot buffer sets that rate.
//   A stalled rsp_ch holds the output register and freezes the sequencer; an idle block
//   still takes a packet that is dropped or whose results wait behind the held register.
//   Reset: window base 0, all slots empty, sequencer idle, no result pending.
module selective_repeat_receive_window
   import srrw_pkg::*;
#(
   parameter int WINDOW_SIZE  = 4,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic       clock,
   input  logic       reset,
   srrw_req_if.sink   req_ch,
   srrw_rsp_if.source rsp_ch
);

   localparam int HEAD_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
   localparam int SUM_W  = ((HEAD_W > SEQ_BITS) ? HEAD_W : SEQ_BITS) + 1;
   localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(WINDOW_SIZE - 1);
   localparam logic [SUM_W-1:0]  WIN_SUM   = SUM_W'(WINDOW_SIZE);

   localparam logic [1:0] ST_IDLE    = 2'd0;
   localparam logic [1:0] ST_ACK     = 2'd1;
   localparam logic [1:0] ST_DELIVER = 2'd2;

   logic [1:0]              state_ff, state_in;
   seq_type                 base_ff, base_in;
   logic [HEAD_W-1:0]       head_ff, head_in;
   logic [HEAD_W-1:0]       cnt_ff, cnt_in;
   logic [WINDOW_SIZE-1:0]  filled_ff, filled_in;
   seq_type                 ack_seq_ff, ack_seq_in;
   logic                    prev_win_ff, prev_win_in;
   logic [PAYLOAD_BITS-1:0] slot_ff [WINDOW_SIZE];

   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_kind_ff, rsp_kind_in;
   seq_type                 rsp_ack_ff, rsp_ack_in;
   logic [PAYLOAD_BITS-1:0] rsp_data_ff, rsp_data_in;
   logic                    rsp_last_ff, rsp_last_in;

   logic              req_acc;
   logic              out_free;
   seq_type           ahead;
   seq_type           behind;
   logic              in_win;
   logic              prev_win;
   logic [SUM_W-1:0]  phys_sum;
   logic [SUM_W-1:0]  phys_wrap;
   logic [HEAD_W-1:0] phys;
   logic [HEAD_W-1:0] head_next;
   logic              slot_we;
   logic              last;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign req_acc      = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign ahead     = req_ch.seq_num - base_ff;
   assign behind    = base_ff - req_ch.seq_num;
   assign in_win    = SUM_W'(ahead) < WIN_SUM;
   assign prev_win  = (behind != '0) && (SUM_W'(behind) <= WIN_SUM);
   assign phys_sum  = SUM_W'(head_ff) + SUM_W'(ahead);
   assign phys_wrap = phys_sum - WIN_SUM;
   assign phys      = (phys_sum >= WIN_SUM) ? HEAD_W'(phys_wrap) : HEAD_W'(phys_sum);
   assign head_next = (head_ff == HEAD_LAST) ? '0 : head_ff + 1'b1;
   assign slot_we   = req_acc && req_ch.checksum_ok && in_win;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      head_in      = head_ff;
      cnt_in       = cnt_ff;
      filled_in    = filled_ff;
      ack_seq_in   = ack_seq_ff;
      prev_win_in  = prev_win_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_kind_in  = rsp_kind_ff;
      rsp_ack_in   = rsp_ack_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      last         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_acc && req_ch.checksum_ok && (in_win || prev_win)) begin
               state_in    = ST_ACK;
               ack_seq_in  = req_ch.seq_num;
               prev_win_in = !in_win;
               if (in_win) begin
                  filled_in[phys] = 1'b1;
               end
            end
         end
         ST_ACK: begin
            last = prev_win_ff || !filled_ff[head_ff];
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_ACK;
               rsp_ack_in   = ack_seq_ff;
               rsp_data_in  = '0;
               rsp_last_in  = last;
               cnt_in       = '0;
               state_in     = last ? ST_IDLE : ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            last = (cnt_ff == HEAD_LAST) || !filled_ff[head_next];
            if (out_free) begin
               rsp_valid_in       = 1'b1;
               rsp_kind_in        = KIND_DATA;
               rsp_ack_in         = '0;
               rsp_data_in        = slot_ff[head_ff];
               rsp_last_in        = last;
               filled_in[head_ff] = 1'b0;
               head_in            = head_next;
               base_in            = base_ff + 1'b1;
               cnt_in             = cnt_ff + 1'b1;
               state_in           = last ? ST_IDLE : ST_DELIVER;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         base_ff      <= '0;
         head_ff      <= '0;
         cnt_ff       <= '0;
         filled_ff    <= '0;
         prev_win_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         head_ff      <= head_in;
         cnt_ff       <= cnt_in;
         filled_ff    <= filled_in;
         prev_win_ff  <= prev_win_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ack_seq_ff  <= ack_seq_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_ack_ff  <= rsp_ack_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
      if (slot_we) begin
         slot_ff[phys] <= req_ch.payload_word;
      end
   end

   assign rsp_ch.valid             = rsp_valid_ff;
   assign rsp_ch.result_kind       = rsp_kind_ff;
   assign rsp_ch.ack_num           = rsp_ack_ff;
   assign rsp_ch.delivered_payload = rsp_data_ff;
   assign rsp_ch.last_of_run       = rsp_last_ff;

   a_deliver_filled: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DELIVER |-> filled_ff[head_ff])
      else $error("delivery from an empty head slot");

   a_deliver_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DELIVER |-> !prev_win_ff)
      else $error("delivery after a previous-window packet");

   a_bad_checksum_drop: assert property (@(posedge clock) disable iff (reset)
      req_acc && !req_ch.checksum_ok |=> state_ff == ST_IDLE && $stable(filled_ff))
      else $error("bad-checksum packet changed state");

endmodule
